### src/tlspq_pkg.sv
// Package: shared types, widths and codes for the three-level priority queue.
`timescale 1ns / 1ps
package tlspq_pkg;

    localparam int CAPACITY     = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TOT_W  = $clog2(RESULT_LIMIT + 1);
    localparam int CMP_W  = (CNT_W > TOT_W) ? CNT_W : TOT_W;

    localparam int ID_W   = 32;
    localparam int PRI_W  = 2;
    localparam int PREQ_W = 3;
    localparam int ORD_W  = 16;
    localparam int CODE_W = 8;
    localparam int CMD_W  = 2;
    localparam int ERR_W  = 3;

    localparam int IN_RAW_W  = CMD_W + ID_W + PREQ_W + ORD_W + CODE_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = ERR_W + ID_W + PRI_W + ORD_W + CODE_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_START  = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_PRI   = 3'd1,
        ERR_FULL      = 3'd2,
        ERR_EMPTY     = 3'd3,
        ERR_NOT_FOUND = 3'd4
    } err_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [ORD_W-1:0]  ord;
        logic [CODE_W-1:0] st;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [PRI_W-1:0] PRI_FIRST = 2'd1;
    localparam logic [PRI_W-1:0] PRI_LAST  = 2'd3;
    localparam logic [CODE_W-1:0] EXAM_RESET = 8'd1;

endpackage

### src/three_level_stable_priority_queue.sv
// Insert writes at the end; start and pop scan the entries, and pop then shifts the rest down.
// Dump walks the table once per priority level: S_DREAD and S_DCHK per entry, S_OUT per result.
// One request at a time: s_tready is high only while the sequencer is idle and no result waits.
// Scan and shift speed is set by the single read port of the entry RAM, one entry per cycle.
// Reset (rst_n low, async) empties the queue and sets exam_code to 1; RAM contents are not cleared.
`timescale 1ns / 1ps
module three_level_stable_priority_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, patient_id, priority_req, reg_order, status_in (from bit 0)
    input  logic [tlspq_pkg::IN_W-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // error, out_id, out_priority, out_order, out_status (from bit 0)
    output logic [tlspq_pkg::OUT_W-1:0]    m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tlspq_pkg::CODE_W-1:0]   cfg_wdata
);
    import tlspq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DREAD,
        S_DCHK,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  chk_reg, chk_next;
    logic              dv_reg, dv_next;
    entry_t            best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PRI_W-1:0]  level_reg, level_next;
    logic [TOT_W-1:0]  k_reg, k_next;
    logic [CODE_W-1:0] exam_reg, exam_next;
    logic              valid_reg, valid_next;
    err_t              err_reg, err_next;
    entry_t            oent_reg, oent_next;
    logic              last_reg, last_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_ent;

    cmd_t              in_cmd;
    logic [ID_W-1:0]   in_id;
    logic [PREQ_W-1:0] in_pri;
    logic [ORD_W-1:0]  in_ord;
    logic [CODE_W-1:0] in_st;

    logic             issue;
    logic [TOT_W-1:0] total;
    entry_t           started;

    assign in_cmd = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_id  = s_tdata[CMD_W +: ID_W];
    assign in_pri = s_tdata[CMD_W+ID_W +: PREQ_W];
    assign in_ord = s_tdata[CMD_W+ID_W+PREQ_W +: ORD_W];
    assign in_st  = s_tdata[CMD_W+ID_W+PREQ_W+ORD_W +: CODE_W];

    assign rd_ent = entry_t'(ram_rdata);
    assign issue  = (idx_reg < count_reg);
    assign total  = (CMP_W'(count_reg) < CMP_W'(RESULT_LIMIT)) ?
                    TOT_W'(count_reg) : TOT_W'(RESULT_LIMIT);

    always_comb
    begin
        started    = rd_ent;
        started.st = exam_reg;
    end

    assign ram_raddr = idx_reg[IDX_W-1:0];

    tlspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        chk_next      = chk_reg;
        dv_next       = dv_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        k_next        = k_reg;
        exam_next     = cfg_we ? cfg_wdata : exam_reg;
        valid_next    = valid_reg;
        err_next      = err_reg;
        oent_next     = oent_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_reg;
        ram_wdata     = rd_ent;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = in_cmd;
                    id_next    = in_id;
                    idx_next   = '0;
                    dv_next    = 1'b0;
                    k_next     = '0;
                    level_next = PRI_FIRST;
                    oent_next  = '0;
                    last_next  = 1'b1;
                    err_next   = ERR_OK;
                    case (in_cmd)
                        CMD_INSERT:
                        begin
                            valid_next = 1'b1;
                            state_next = S_OUT;
                            if (in_pri == '0 || in_pri > PREQ_W'(PRI_LAST))
                            begin
                                err_next = ERR_BAD_PRI;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = '{id: in_id, pri: in_pri[PRI_W-1:0],
                                               ord: in_ord, st: in_st};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP, CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next   = ERR_EMPTY;
                                valid_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = (in_cmd == CMD_POP) ? S_SCAN : S_DREAD;
                            end
                        end
                        CMD_START:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // walk entries 0..n-1, one read issued per cycle, data checked in the next cycle
            S_SCAN:
            begin
                dv_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    chk_next = idx_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if (cmd_reg == CMD_START)
                    begin
                        if (rd_ent.id == id_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = chk_reg;
                            ram_wdata  = started;
                            oent_next  = started;
                            err_next   = ERR_OK;
                            dv_next    = 1'b0;
                            valid_next = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                    else if (chk_reg == '0 || rd_ent.pri < best_reg.pri)
                    begin
                        best_next     = rd_ent;
                        best_idx_next = chk_reg;
                    end
                end
                else if (!issue)
                begin
                    if (cmd_reg == CMD_START)
                    begin
                        err_next   = ERR_NOT_FOUND;
                        valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(best_idx_reg) + 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end

            // close the gap: read entry i, write it to i-1
            S_SHIFT:
            begin
                dv_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    chk_next = idx_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_reg - 1'b1;
                    ram_wdata = rd_ent;
                end
                else if (!issue)
                begin
                    count_next = count_reg - 1'b1;
                    oent_next  = best_reg;
                    err_next   = ERR_OK;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_DREAD:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next   = '0;
                    level_next = level_reg + 1'b1;
                    if (level_reg == PRI_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DCHK;
                end
            end

            S_DCHK:
            begin
                if (rd_ent.pri == level_reg)
                begin
                    oent_next  = rd_ent;
                    err_next   = ERR_OK;
                    last_next  = ((k_reg + 1'b1) == total);
                    k_next     = k_reg + 1'b1;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DREAD;
                end
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    state_next = (cmd_reg == CMD_DUMP && !last_reg) ? S_DREAD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_INSERT;
            id_reg       <= '0;
            idx_reg      <= '0;
            chk_reg      <= '0;
            dv_reg       <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
            count_reg    <= '0;
            level_reg    <= PRI_FIRST;
            k_reg        <= '0;
            exam_reg     <= EXAM_RESET;
            valid_reg    <= 1'b0;
            err_reg      <= ERR_OK;
            oent_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            id_reg       <= id_next;
            idx_reg      <= idx_next;
            chk_reg      <= chk_next;
            dv_reg       <= dv_next;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            count_reg    <= count_next;
            level_reg    <= level_next;
            k_reg        <= k_next;
            exam_reg     <= exam_next;
            valid_reg    <= valid_next;
            err_reg      <= err_next;
            oent_reg     <= oent_next;
            last_reg     <= last_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(OUT_W-OUT_RAW_W){1'b0}}, oent_reg.st, oent_reg.ord,
                       oent_reg.pri, oent_reg.id, err_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("new request taken while a result is pending");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_cmd == CMD_INSERT && in_pri != '0
         && in_pri <= PREQ_W'(PRI_LAST) && count_reg != CNT_W'(CAPACITY))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not add an entry");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && err_reg != ERR_OK) |-> m_tlast)
        else $error("error result not marked last");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DCHK || state_reg == S_DREAD) |-> k_reg < total)
        else $error("dump walked past its result count");

endmodule

### src/tlspq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tlspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
